[hw/rtl/lgwd_pkg.sv]
// Shared constants, types and the reciprocal table of the line gradient window filter.
`default_nettype none

package lgwd_pkg;

   localparam int MAX_WINDOW_DEF = 16;
   localparam int MAX_LINE_DEF   = 4096;

   localparam int PIX_W      = 8;
   localparam int MODE_W     = 2;
   localparam int COEF_W     = 11;
   localparam int LEVEL_W    = 8;
   localparam int WLEN_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int RECIP_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int RECIP_BIAS = 100;

   localparam int CMD_DEPTH = 2;
   localparam int RES_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIFF_MODE  = 3'd0,
      CSR_GAIN       = 3'd1,
      CSR_OFFSET     = 3'd2,
      CSR_MIN_LEVEL  = 3'd3,
      CSR_WINDOW_LEN = 3'd4
   } lgwd_csr_type;

   localparam logic [MODE_W-1:0] MODE_PREV_MINUS_NEXT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEXT_MINUS_PREV = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NORM_ABS        = 2'd2;

   localparam logic [MODE_W-1:0]  RST_DIFF_MODE  = MODE_PREV_MINUS_NEXT;
   localparam logic [COEF_W-1:0]  RST_GAIN       = 11'd1;
   localparam logic [COEF_W-1:0]  RST_OFFSET     = 11'd0;
   localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL  = 8'd5;
   localparam logic [WLEN_W-1:0]  RST_WINDOW_LEN = 5'd2;

   // Classification of one pixel, decided by the front end.
   typedef struct packed {
      logic last;
      logic emit;
      logic margin;
      logic sub_next;
      logic sub_prev;
   } lgwd_flags_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_RD_OLD,
      ST_SHIFT,
      ST_TEST,
      ST_MUL,
      ST_SUM,
      ST_DIV_GO,
      ST_DIV,
      ST_EMIT,
      ST_FLUSH_RD,
      ST_FLUSH_WR
   } lgwd_state_type;

   typedef logic [255:0][RECIP_W-1:0] recip_tab_type;

   // Largest m with (2m-1)^5 * (p+100) <= 2^85, i.e. round(65536 * (p+100)^-0.2).
   function automatic logic [RECIP_W-1:0] recip_entry(input int p);
      logic [127:0] v;
      logic [127:0] z;
      logic [16:0]  lo;
      logic [16:0]  hi;
      logic [16:0]  mid;
      lo = 17'd1;
      hi = 17'd65536;
      for (int it = 0; it < 18; it++) begin
         if (hi - lo > 17'd1) begin
            mid = (lo + hi) >> 1;
            z   = 128'(mid) * 128'd2 - 128'd1;
            v   = 128'(p + RECIP_BIAS);
            for (int n = 0; n < 5; n++) begin
               v = v * z;
            end
            if (v <= (128'd1 << 85)) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
      end
      return lo[RECIP_W-1:0];
   endfunction

   function automatic recip_tab_type build_recip();
      recip_tab_type t;
      for (int p = 0; p < 256; p++) begin
         t[p] = recip_entry(p);
      end
      return t;
   endfunction

   localparam recip_tab_type RECIP_TAB = build_recip();

endpackage

`default_nettype wire

[hw/rtl/lgwd_fifo.sv]
// Small first-in first-out queue used between the block's stages.
`default_nettype none

module lgwd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lgwd_front.sv]
// Front end: accepts pixels, tracks the line position and classifies each pixel.
`default_nettype none

module lgwd_front #(
   parameter int MAX_WINDOW = lgwd_pkg::MAX_WINDOW_DEF,
   parameter int MAX_LINE   = lgwd_pkg::MAX_LINE_DEF,
   parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [lgwd_pkg::WLEN_W-1:0] window_len,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [lgwd_pkg::PIX_W-1:0]  pixel_in,
   input  wire logic                        last_in_line,
   output logic                             cmd_push,
   input  wire logic                        cmd_full,
   output logic      [lgwd_pkg::PIX_W-1:0]  cmd_pix,
   output lgwd_pkg::lgwd_flags_type         cmd_flags,
   output logic      [WIN_W-1:0]            cmd_win,
   output logic      [WIN_W-1:0]            cmd_flush
);

   localparam int LP_W   = $clog2(MAX_LINE);
   localparam int LPX_W  = ((LP_W > WIN_W + 1) ? LP_W : WIN_W + 1) + 1;
   localparam int FILL_W = $clog2(2 * MAX_WINDOW + 1);
   localparam int PEND_W = $clog2(MAX_WINDOW + 2);

   logic [LP_W-1:0]   lp_ff, lp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [WIN_W-1:0]  win_new;
   logic [PEND_W-1:0] pend_inc, pend_after;
   logic [LPX_W-1:0]  lp_x, w_x;
   logic              accept;

   assign full     = cmd_full;
   assign accept   = push && !cmd_full;
   assign cmd_push = accept;

   // The window length is sampled only at the first pixel of a line.
   always_comb begin
      if (window_len == '0) begin
         win_new = WIN_W'(1);
      end else if (int'(window_len) > MAX_WINDOW) begin
         win_new = WIN_W'(MAX_WINDOW);
      end else begin
         win_new = WIN_W'(window_len);
      end
   end

   always_comb begin
      win_in     = (lp_ff == '0) ? win_new : win_ff;
      pend_inc   = pend_ff + 1'b1;
      lp_x       = LPX_W'(lp_ff);
      w_x        = LPX_W'(win_in);

      cmd_flags.last     = last_in_line;
      cmd_flags.emit     = (pend_inc > PEND_W'(win_in));
      cmd_flags.margin   = (lp_x >= w_x) ? (lp_x + 1'b1 >= (w_x << 1)) : (w_x <= LPX_W'(1));
      cmd_flags.sub_next = (fill_ff >= FILL_W'(win_in));
      cmd_flags.sub_prev = (fill_ff >= FILL_W'({win_in, 1'b0}));

      pend_after = cmd_flags.emit ? PEND_W'(win_in) : pend_inc;
      cmd_pix    = pixel_in;
      cmd_win    = win_in;
      cmd_flush  = WIN_W'(pend_after);

      lp_in   = lp_ff;
      fill_in = fill_ff;
      pend_in = pend_ff;
      if (accept) begin
         if (last_in_line) begin
            lp_in   = '0;
            fill_in = '0;
            pend_in = '0;
         end else begin
            if (lp_ff != LP_W'(MAX_LINE - 1)) begin
               lp_in = lp_ff + 1'b1;
            end
            if (fill_ff != FILL_W'(2 * MAX_WINDOW)) begin
               fill_in = fill_ff + 1'b1;
            end
            pend_in = pend_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff   <= '0;
         fill_ff <= '0;
         pend_ff <= '0;
         win_ff  <= WIN_W'(2);
      end else begin
         lp_ff   <= lp_in;
         fill_ff <= fill_in;
         pend_ff <= pend_in;
         if (accept) begin
            win_ff <= win_in;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lgwd_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module lgwd_div #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic      [DIVIDEND_W-1:0] quotient,
   output logic      [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   always_comb begin
      trial   = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIVIDEND_W-2:0], ge};
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

endmodule

`default_nettype wire

[hw/rtl/lgwd_back.sv]
// Back end: pixel history memory, running window sums and the rewrite arithmetic.
`default_nettype none

module lgwd_back #(
   parameter int MAX_WINDOW = lgwd_pkg::MAX_WINDOW_DEF,
   parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [lgwd_pkg::MODE_W-1:0]  diff_mode,
   input  wire logic [lgwd_pkg::COEF_W-1:0]  gain,
   input  wire logic [lgwd_pkg::COEF_W-1:0]  offset,
   input  wire logic [lgwd_pkg::LEVEL_W-1:0] min_level,
   input  wire logic                         cmd_empty,
   output logic                              cmd_pop,
   input  wire logic [lgwd_pkg::PIX_W-1:0]   cmd_pix,
   input  wire lgwd_pkg::lgwd_flags_type     cmd_flags,
   input  wire logic [WIN_W-1:0]             cmd_win,
   input  wire logic [WIN_W-1:0]             cmd_flush,
   input  wire logic                         res_full,
   output logic                              res_push,
   output logic      [lgwd_pkg::PIX_W-1:0]   res_pixel,
   output logic                              res_last
);

   localparam int PW      = lgwd_pkg::PIX_W;
   localparam int CW      = lgwd_pkg::COEF_W;
   localparam int FW      = lgwd_pkg::FRAC_W;
   localparam int AW      = $clog2(2 * MAX_WINDOW);
   localparam int DEPTH   = 1 << AW;
   localparam int SUM_W   = $clog2(MAX_WINDOW * 255 + 1);
   localparam int D_W     = SUM_W + 1;
   localparam int GD_W    = CW + D_W;
   localparam int OW_W    = CW + WIN_W + 1;
   localparam int PROD_W  = GD_W + lgwd_pkg::RECIP_W + 1;
   localparam int NUM_W   = PROD_W + 1;
   localparam int Q_W     = NUM_W - FW - 1;
   localparam int MW      = lgwd_pkg::LEVEL_W + WIN_W;
   localparam int CMP_W   = (SUM_W > MW) ? SUM_W : MW;

   lgwd_pkg::lgwd_state_type state_ff, state_in;

   logic [PW-1:0]              mem [DEPTH];
   logic [PW-1:0]              rd_data_ff;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [PW-1:0]              wr_data;

   logic [PW-1:0]              pix_ff, pix_in;
   lgwd_pkg::lgwd_flags_type   flags_ff, flags_in;
   logic [WIN_W-1:0]           w_ff, w_in;
   logic [WIN_W-1:0]           j_ff, j_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [SUM_W-1:0]           nsum_ff, nsum_in;
   logic [SUM_W-1:0]           psum_ff, psum_in;
   logic [PW-1:0]              cur_ff, cur_in;
   logic [PW-1:0]              res_ff, res_in;
   logic                       proc_ff, proc_in;
   logic [lgwd_pkg::RECIP_W-1:0] recip_ff, recip_in;
   logic signed [GD_W-1:0]     gd_ff, gd_in;
   logic signed [OW_W-1:0]     ow_ff, ow_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [NUM_W-1:0]    num_ff, num_in;

   logic signed [D_W-1:0]      d_val, d_abs, d_sel;
   logic [MW-1:0]              min_w;
   logic                       take;
   logic                       mode_abs, mode_neg;
   logic [PW-1:0]              old_val;

   logic                       div_start, div_done;
   logic [Q_W-1:0]             div_q;
   logic [WIN_W-1:0]           div_r;
   logic [WIN_W+FW:0]          twice_r, den;
   logic                       round_up;
   logic [Q_W:0]               q_up;
   logic [PW-1:0]              rounded;

   assign mode_abs = diff_mode[1];
   assign mode_neg = (diff_mode == lgwd_pkg::MODE_NEXT_MINUS_PREV);
   assign old_val  = rd_data_ff;

   lgwd_div #(
      .DIVIDEND_W (Q_W),
      .DIVISOR_W  (WIN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (num_ff[NUM_W-2:FW]),
      .divisor   (w_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Round half to even on the full remainder, then clamp to a pixel.
   always_comb begin
      twice_r  = {div_r, num_ff[FW-1:0], 1'b0};
      den      = {1'b0, w_ff, {FW{1'b0}}};
      round_up = (twice_r > den) || ((twice_r == den) && div_q[0]);
      q_up     = (Q_W + 1)'(div_q) + (Q_W + 1)'(round_up);
      rounded  = (q_up > (Q_W + 1)'(255)) ? {PW{1'b1}} : q_up[PW-1:0];
   end

   always_comb begin
      d_val = $signed({1'b0, psum_ff}) - $signed({1'b0, nsum_ff});
      d_abs = d_val[D_W-1] ? -d_val : d_val;
      d_sel = mode_abs ? d_abs : d_val;
      min_w = MW'(min_level) * MW'(w_ff);
      take  = flags_ff.margin && (cur_ff > min_level) &&
              (CMP_W'(psum_ff) > CMP_W'(min_w)) && (CMP_W'(nsum_ff) > CMP_W'(min_w));
   end

   always_comb begin
      state_in  = state_ff;
      pix_in    = pix_ff;
      flags_in  = flags_ff;
      w_in      = w_ff;
      j_in      = j_ff;
      wp_in     = wp_ff;
      nsum_in   = nsum_ff;
      psum_in   = psum_ff;
      cur_in    = cur_ff;
      res_in    = res_ff;
      proc_in   = proc_ff;
      recip_in  = recip_ff;
      gd_in     = gd_ff;
      ow_in     = ow_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      cmd_pop   = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = wp_ff;
      wr_en     = 1'b0;
      wr_addr   = wp_ff;
      wr_data   = pix_ff;
      div_start = 1'b0;
      res_push  = 1'b0;
      res_pixel = res_ff;
      res_last  = 1'b0;

      case (state_ff)
         lgwd_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               pix_in   = cmd_pix;
               flags_in = cmd_flags;
               w_in     = cmd_win;
               j_in     = cmd_flush - 1'b1;
               state_in = lgwd_pkg::ST_RD_CUR;
            end
         end
         lgwd_pkg::ST_RD_CUR: begin
            rd_en    = 1'b1;
            rd_addr  = wp_ff - AW'(w_ff - 1'b1);
            state_in = lgwd_pkg::ST_RD_OLD;
         end
         lgwd_pkg::ST_RD_OLD: begin
            rd_en    = 1'b1;
            rd_addr  = wp_ff - AW'({w_ff, 1'b0} - 1'b1);
            cur_in   = rd_data_ff;
            state_in = lgwd_pkg::ST_SHIFT;
         end
         lgwd_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = wp_ff + 1'b1;
            wr_data = pix_ff;
            wp_in   = wp_ff + 1'b1;
            nsum_in = nsum_ff + SUM_W'(pix_ff)
                      - (flags_ff.sub_next ? SUM_W'(cur_ff) : '0);
            psum_in = psum_ff + (flags_ff.sub_next ? SUM_W'(cur_ff) : '0)
                      - (flags_ff.sub_prev ? SUM_W'(old_val) : '0);
            if (flags_ff.emit) begin
               state_in = lgwd_pkg::ST_TEST;
            end else if (flags_ff.last) begin
               state_in = lgwd_pkg::ST_FLUSH_RD;
            end else begin
               state_in = lgwd_pkg::ST_IDLE;
            end
         end
         lgwd_pkg::ST_TEST: begin
            res_in   = cur_ff;
            proc_in  = 1'b0;
            recip_in = lgwd_pkg::RECIP_TAB[cur_ff];
            gd_in    = GD_W'($signed(gain)) * GD_W'(d_sel);
            ow_in    = OW_W'($signed(offset)) * OW_W'($signed({1'b0, w_ff}));
            state_in = take ? lgwd_pkg::ST_MUL : lgwd_pkg::ST_EMIT;
         end
         lgwd_pkg::ST_MUL: begin
            if (mode_abs) begin
               prod_in = PROD_W'(gd_ff) * PROD_W'($signed({1'b0, recip_ff}));
            end else begin
               prod_in = PROD_W'(mode_neg ? -gd_ff : gd_ff) <<< FW;
            end
            state_in = lgwd_pkg::ST_SUM;
         end
         lgwd_pkg::ST_SUM: begin
            num_in   = NUM_W'(prod_ff) + (NUM_W'(ow_ff) <<< FW);
            state_in = lgwd_pkg::ST_DIV_GO;
         end
         lgwd_pkg::ST_DIV_GO: begin
            proc_in = 1'b1;
            if (num_ff[NUM_W-1]) begin
               // A negative numerator always lands at zero after clamping.
               res_in   = '0;
               state_in = lgwd_pkg::ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = lgwd_pkg::ST_DIV;
            end
         end
         lgwd_pkg::ST_DIV: begin
            if (div_done) begin
               res_in   = rounded;
               state_in = lgwd_pkg::ST_EMIT;
            end
         end
         lgwd_pkg::ST_EMIT: begin
            if (!res_full) begin
               res_push  = 1'b1;
               res_pixel = res_ff;
               if (proc_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = wp_ff - AW'(w_ff);
                  wr_data = res_ff;
                  psum_in = psum_ff - SUM_W'(cur_ff) + SUM_W'(res_ff);
               end
               state_in = flags_ff.last ? lgwd_pkg::ST_FLUSH_RD : lgwd_pkg::ST_IDLE;
            end
         end
         lgwd_pkg::ST_FLUSH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = wp_ff - AW'(j_ff);
            state_in = lgwd_pkg::ST_FLUSH_WR;
         end
         lgwd_pkg::ST_FLUSH_WR: begin
            if (!res_full) begin
               res_push  = 1'b1;
               res_pixel = rd_data_ff;
               res_last  = (j_ff == '0);
               if (j_ff == '0) begin
                  nsum_in  = '0;
                  psum_in  = '0;
                  state_in = lgwd_pkg::ST_IDLE;
               end else begin
                  j_in     = j_ff - 1'b1;
                  state_in = lgwd_pkg::ST_FLUSH_RD;
               end
            end
         end
         default: begin
            state_in = lgwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgwd_pkg::ST_IDLE;
         wp_ff    <= '0;
         nsum_ff  <= '0;
         psum_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         nsum_ff  <= nsum_in;
         psum_ff  <= psum_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff   <= pix_in;
      flags_ff <= flags_in;
      w_ff     <= w_in;
      j_ff     <= j_in;
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      proc_ff  <= proc_in;
      recip_ff <= recip_in;
      gd_ff    <= gd_in;
      ow_ff    <= ow_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/line_gradient_window_diff_top.sv]
// Top level of the line gradient window filter: ports, configuration registers, queues.
//
// Usage. Pixels of a line enter on a queue-style port: a transaction happens at a rising
// edge with push high and full low; last_in_line marks the final pixel of the line.
// Results leave on a second queue port: the oldest result sits on rsp_pixel_out and
// rsp_last_out while empty is low, and a transaction happens when pop is high and empty
// is low. Each pixel comes back in line order, window_len pixels later; the pixel that
// carries last_in_line also releases all pending pixels, the final one with rsp_last_out.
// Configuration registers are written through valid/ready with csr_index and csr_data;
// ready is always high. Writes must be made only while the block is idle; the block itself
// does not enforce this. A front end classifies each pixel as it is accepted and queues
// it; a back end handles one pixel at a time. Each pixel reads the history twice and is
// shifted into it; one that leaves unchanged is tested and emitted, and a rewritten one
// is tested, multiplied, summed, sent to the iterative divider by the window length (one
// quotient bit per cycle, a 25-bit quotient at default sizes) and emitted; a negative
// numerator skips the divider. Each pixel released at the end of a line is read from the
// history memory and written out. Reset clears the queues, line position and window sums;
// the registers return to their defaults. When the receiver stalls, the result queue
// fills, the back end holds, the command queue fills and full rises; nothing is dropped.
`default_nettype none

module line_gradient_window_diff_top #(
   parameter int MAX_WINDOW = lgwd_pkg::MAX_WINDOW_DEF,
   parameter int MAX_LINE   = lgwd_pkg::MAX_LINE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic [lgwd_pkg::PIX_W-1:0]      req_pixel_in,
   input  wire logic                            req_last_in_line,
   output logic                                 empty,
   input  wire logic                            pop,
   output logic      [lgwd_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic                                 rsp_last_out,
   input  wire logic                            valid,
   output logic                                 ready,
   input  wire logic [lgwd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lgwd_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int FLG_W = $bits(lgwd_pkg::lgwd_flags_type);
   localparam int CMD_W = lgwd_pkg::PIX_W + FLG_W + 2 * WIN_W;
   localparam int RES_W = lgwd_pkg::PIX_W + 1;

   logic [lgwd_pkg::MODE_W-1:0]  diff_mode_ff;
   logic [lgwd_pkg::COEF_W-1:0]  gain_ff;
   logic [lgwd_pkg::COEF_W-1:0]  offset_ff;
   logic [lgwd_pkg::LEVEL_W-1:0] min_level_ff;
   logic [lgwd_pkg::WLEN_W-1:0]  window_len_ff;

   logic                         cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [lgwd_pkg::PIX_W-1:0]   f_pix;
   lgwd_pkg::lgwd_flags_type     f_flags;
   logic [WIN_W-1:0]             f_win, f_flush;
   logic [CMD_W-1:0]             cmd_wdata, cmd_rdata;
   lgwd_pkg::lgwd_flags_type     b_flags;

   logic                         res_push, res_full, res_last;
   logic [lgwd_pkg::PIX_W-1:0]   res_pixel;
   logic [RES_W-1:0]             res_rdata;

   assign ready = 1'b1;

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_mode_ff  <= lgwd_pkg::RST_DIFF_MODE;
         gain_ff       <= lgwd_pkg::RST_GAIN;
         offset_ff     <= lgwd_pkg::RST_OFFSET;
         min_level_ff  <= lgwd_pkg::RST_MIN_LEVEL;
         window_len_ff <= lgwd_pkg::RST_WINDOW_LEN;
      end else if (valid && ready) begin
         case (lgwd_pkg::lgwd_csr_type'(csr_index))
            lgwd_pkg::CSR_DIFF_MODE:  diff_mode_ff  <= csr_data[lgwd_pkg::MODE_W-1:0];
            lgwd_pkg::CSR_GAIN:       gain_ff       <= csr_data[lgwd_pkg::COEF_W-1:0];
            lgwd_pkg::CSR_OFFSET:     offset_ff     <= csr_data[lgwd_pkg::COEF_W-1:0];
            lgwd_pkg::CSR_MIN_LEVEL:  min_level_ff  <= csr_data[lgwd_pkg::LEVEL_W-1:0];
            lgwd_pkg::CSR_WINDOW_LEN: window_len_ff <= csr_data[lgwd_pkg::WLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lgwd_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_LINE   (MAX_LINE),
      .WIN_W      (WIN_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .window_len   (window_len_ff),
      .push         (push),
      .full         (full),
      .pixel_in     (req_pixel_in),
      .last_in_line (req_last_in_line),
      .cmd_push     (cmd_push),
      .cmd_full     (cmd_full),
      .cmd_pix      (f_pix),
      .cmd_flags    (f_flags),
      .cmd_win      (f_win),
      .cmd_flush    (f_flush)
   );

   assign cmd_wdata = {f_pix, f_flags, f_win, f_flush};

   lgwd_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (lgwd_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   assign b_flags = cmd_rdata[2*WIN_W +: FLG_W];

   lgwd_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .WIN_W      (WIN_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .diff_mode (diff_mode_ff),
      .gain      (gain_ff),
      .offset    (offset_ff),
      .min_level (min_level_ff),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_pix   (cmd_rdata[CMD_W-1 -: lgwd_pkg::PIX_W]),
      .cmd_flags (b_flags),
      .cmd_win   (cmd_rdata[WIN_W +: WIN_W]),
      .cmd_flush (cmd_rdata[WIN_W-1:0]),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_pixel (res_pixel),
      .res_last  (res_last)
   );

   lgwd_fifo #(
      .WIDTH (RES_W),
      .DEPTH (lgwd_pkg::RES_DEPTH)
   ) u_res_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata ({res_pixel, res_last}),
      .full  (res_full),
      .pop   (pop),
      .rdata (res_rdata),
      .empty (empty)
   );

   assign rsp_pixel_out = res_rdata[RES_W-1:1];
   assign rsp_last_out  = res_rdata[0];

   // The back end must never offer a result the queue cannot hold.
   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

   // The back end only takes a command that is really waiting.
   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from an empty queue");

   // The front end only queues a pixel while there is room for it.
   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into a full queue");

endmodule

`default_nettype wire
